@@ hdl/srv_pkg.sv @@
// Shared types, constants and the CRC byte step for the settings record validator.
package srv_pkg;

  localparam int RECORD_BYTES_DEF = 512;

  localparam logic [31:0] MAGIC_WORD = 32'h52424b59;
  localparam logic [31:0] CRC_POLY   = 32'hedb88320;
  localparam logic [31:0] CRC_INIT   = 32'hffffffff;
  localparam logic [7:0]  MARKER     = 8'ha5;
  localparam logic [7:0]  VOL_MAX    = 8'd100;
  localparam logic [15:0] FREQ_MIN   = 16'd300;
  localparam logic [15:0] FREQ_MAX   = 16'd1200;
  localparam logic [15:0] SIZE_V23   = 16'd262;
  localparam logic [15:0] SIZE_V1    = 16'd260;
  localparam logic [15:0] VER_1      = 16'd1;
  localparam logic [15:0] VER_2      = 16'd2;
  localparam logic [15:0] VER_3      = 16'd3;

  // Byte offsets of the header fields and the payload window
  localparam int POS_VER     = 4;
  localparam int POS_SIZE    = 6;
  localparam int POS_SEQ     = 8;
  localparam int POS_CRC     = 12;
  localparam int POS_PAYLOAD = 16;
  localparam int POS_END     = 23;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PTT_MAX = 2'd2;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_VERSZ  = 3'd2,
    ERR_LIMITS = 3'd3,
    ERR_CRC    = 3'd4,
    ERR_LENGTH = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_V3   = 2'd1,
    KIND_V2   = 2'd2,
    KIND_V1   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] out_mode_min;
    logic [7:0] out_mode_max;
    logic [7:0] ptt_mode_max;
  } cfg_t;

  // Record as seen after the current byte has been folded in
  typedef struct packed {
    logic        length_ok;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] size;
    logic [31:0] sequence_num;
    logic [31:0] stored_crc;
    logic [31:0] crc;
    logic [55:0] payload;
  } rec_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ hdl/srv_if.sv @@
// Stream interfaces for record bytes in and check results out.
interface srv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srv_out_if;
  logic        valid;
  logic        ready;
  logic        record_valid;
  logic [1:0]  format_kind;
  logic [2:0]  error_code;
  logic [31:0] sequence_number;

  modport source (output valid, output record_valid, output format_kind, output error_code,
                  output sequence_number, input ready);
  modport sink   (input valid, input record_valid, input format_kind, input error_code,
                  input sequence_number, output ready);
endinterface

@@ hdl/settings_record_validator.sv @@
// Settings record validator: top level with input register and configuration registers.
//
// Takes one record byte per transaction, in address order, and returns one result
// transaction for every byte marked last. A byte can be accepted in every clock cycle,
// except while a last byte waits in the input register for the result register to free;
// the last byte passes through the input register, then its result is loaded into the
// result register and held there until it is taken.
// The whole per-byte step (field capture, byte-wide CRC-32 update and, on the last
// byte, all header, payload and CRC checks) sits between those two registers. A
// finished result may wait in the output register while the next record streams in;
// only a second last byte stalls until the result is taken. Write the three mode
// bounds only while no record is in flight. The header layout is little endian:
// magic, version, size, sequence, CRC; the CRC covers the whole record with the CRC
// field read as zeros. A record of the wrong length reports error 5 regardless of
// its content; bytes past RecordBytes are counted but otherwise ignored.
module settings_record_validator #(
  parameter int RecordBytes = srv_pkg::RECORD_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [7:0]                     cfg_data_i,
  srv_in_if.sink                         in_i,
  srv_out_if.source                      out_o
);
  import srv_pkg::*;

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       in_take;

  cfg_t  cfg_q, cfg_d;
  rec_t  rec;
  logic  res_free;
  logic  res_load;

  // Advance the input register unless it holds a last byte and the result slot is full
  assign s1_adv   = s1_valid_q && (!s1_last_q || res_free);
  assign res_load = s1_adv && s1_last_q;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take  = in_i.valid && in_i.ready;
  assign s1_valid_d = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Hold the payload of the input register until it advances
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // Configuration registers; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUT_MIN: cfg_d.out_mode_min = cfg_data_i;
        CFG_OUT_MAX: cfg_d.out_mode_max = cfg_data_i;
        CFG_PTT_MAX: cfg_d.ptt_mode_max = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_mode_min <= 8'd0;
      cfg_q.out_mode_max <= 8'd2;
      cfg_q.ptt_mode_max <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  srv_capture #(
    .RecordBytes(RecordBytes)
  ) u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (s1_adv),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .rec_o  (rec)
  );

  srv_check u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_load),
    .rec_i  (rec),
    .cfg_i  (cfg_q),
    .free_o (res_free),
    .out_o  (out_o)
  );

  // A closed record always shows up as a result in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_o.valid)
    else $error("result not presented after record close");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !res_load)
    else $error("pending result overwritten");

  // A passing record names its version and reports no error
  a_valid_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.record_valid) |->
      (out_o.error_code == ERR_OK && out_o.format_kind != KIND_NONE))
    else $error("record_valid inconsistent with error_code or format_kind");

  // Header-level and length failures carry no format kind
  a_kind_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.error_code == ERR_MAGIC || out_o.error_code == ERR_VERSZ ||
     out_o.error_code == ERR_LENGTH)) |-> out_o.format_kind == KIND_NONE)
    else $error("format_kind set on header or length failure");

endmodule

@@ hdl/srv_capture.sv @@
// Byte counter, header and payload capture, and running CRC.
module srv_capture #(
  parameter int RecordBytes = srv_pkg::RECORD_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         take_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output srv_pkg::rec_t rec_o
);
  import srv_pkg::*;

  localparam int CntW = $clog2(RecordBytes + 2);

  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     magic_q, magic_d;
  logic [15:0]     version_q, version_d;
  logic [15:0]     size_q, size_d;
  logic [31:0]     seq_q, seq_d;
  logic [31:0]     scrc_q, scrc_d;
  logic [55:0]     payload_q, payload_d;

  logic [CntW-1:0] pos;
  logic [CntW-1:0] pl_off;
  logic [2:0]      pl_idx;
  logic            in_rec;
  logic            in_crc_field;

  assign pos          = count_q;
  assign pl_off       = pos - CntW'(POS_PAYLOAD);
  assign pl_idx       = pl_off[2:0];
  assign in_rec       = count_q < CntW'(RecordBytes);
  assign in_crc_field = (pos >= CntW'(POS_CRC)) && (pos < CntW'(POS_PAYLOAD));

  always_comb begin
    count_d   = count_q;
    crc_d     = crc_q;
    magic_d   = magic_q;
    version_d = version_q;
    size_d    = size_q;
    seq_d     = seq_q;
    scrc_d    = scrc_q;
    payload_d = payload_q;
    if (take_i && in_rec) begin
      if (pos < CntW'(POS_VER)) begin
        magic_d[{pos[1:0], 3'b000} +: 8] = byte_i;
      end else if (pos < CntW'(POS_SIZE)) begin
        version_d[{pos[0], 3'b000} +: 8] = byte_i;
      end else if (pos < CntW'(POS_SEQ)) begin
        size_d[{pos[0], 3'b000} +: 8] = byte_i;
      end else if (pos < CntW'(POS_CRC)) begin
        seq_d[{pos[1:0], 3'b000} +: 8] = byte_i;
      end else if (pos < CntW'(POS_PAYLOAD)) begin
        scrc_d[{pos[1:0], 3'b000} +: 8] = byte_i;
      end else if (pos < CntW'(POS_END)) begin
        payload_d[{pl_idx, 3'b000} +: 8] = byte_i;
      end
      // The stored CRC field counts as zeros
      crc_d = crc32_byte(crc_q, in_crc_field ? 8'd0 : byte_i);
    end
    if (take_i && (count_q <= CntW'(RecordBytes))) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    rec_o.length_ok    = count_d == CntW'(RecordBytes);
    rec_o.magic        = magic_d;
    rec_o.version      = version_d;
    rec_o.size         = size_d;
    rec_o.sequence_num = seq_d;
    rec_o.stored_crc   = scrc_d;
    rec_o.crc          = crc_d;
    rec_o.payload      = payload_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      crc_q     <= CRC_INIT;
      magic_q   <= '0;
      version_q <= '0;
      size_q    <= '0;
      seq_q     <= '0;
      scrc_q    <= '0;
      payload_q <= '0;
    end else if (take_i && last_i) begin
      // Record closed: start the next one fresh
      count_q   <= '0;
      crc_q     <= CRC_INIT;
      magic_q   <= '0;
      version_q <= '0;
      size_q    <= '0;
      seq_q     <= '0;
      scrc_q    <= '0;
      payload_q <= '0;
    end else begin
      count_q   <= count_d;
      crc_q     <= crc_d;
      magic_q   <= magic_d;
      version_q <= version_d;
      size_q    <= size_d;
      seq_q     <= seq_d;
      scrc_q    <= scrc_d;
      payload_q <= payload_d;
    end
  end

endmodule

@@ hdl/srv_check.sv @@
// Record checks and the result register.
module srv_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  srv_pkg::rec_t rec_i,
  input  srv_pkg::cfg_t cfg_i,
  output logic          free_o,
  srv_out_if.source     out_o
);
  import srv_pkg::*;

  logic [7:0]  pb [7];
  logic [15:0] freq;
  kind_e       kind;
  err_e        err;
  logic        sane;

  logic        valid_q, valid_d;
  logic        rv_q;
  kind_e       kind_q;
  err_e        err_q;
  logic [31:0] seq_q;

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      pb[k] = rec_i.payload[8*k +: 8];
    end
  end

  assign freq = {pb[3], pb[2]};

  always_comb begin
    kind = KIND_NONE;
    err  = ERR_OK;
    sane = 1'b0;
    if (!rec_i.length_ok) begin
      err = ERR_LENGTH;
    end else if (rec_i.magic != MAGIC_WORD) begin
      err = ERR_MAGIC;
    end else begin
      if (rec_i.version == VER_3 && rec_i.size == SIZE_V23) begin
        kind = KIND_V3;
      end else if (rec_i.version == VER_2 && rec_i.size == SIZE_V23) begin
        kind = KIND_V2;
      end else if (rec_i.version == VER_1 && rec_i.size == SIZE_V1) begin
        kind = KIND_V1;
      end
      if (kind == KIND_NONE) begin
        err = ERR_VERSZ;
      end else begin
        sane = (pb[0] <= VOL_MAX) && (pb[1] <= VOL_MAX) &&
               (freq >= FREQ_MIN) && (freq <= FREQ_MAX);
        if (kind == KIND_V1) begin
          sane = sane && (pb[4] == MARKER);
        end else begin
          sane = sane && (pb[4] >= cfg_i.out_mode_min) &&
                 (pb[4] <= cfg_i.out_mode_max) && (pb[6] == MARKER);
          if (kind == KIND_V3) begin
            sane = sane && (pb[5] <= cfg_i.ptt_mode_max);
          end
        end
        if (!sane) begin
          err = ERR_LIMITS;
        end else if (~rec_i.crc != rec_i.stored_crc) begin
          err = ERR_CRC;
        end
      end
    end
  end

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rv_q   <= err == ERR_OK;
      kind_q <= kind;
      err_q  <= err;
      seq_q  <= rec_i.sequence_num;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.record_valid    = rv_q;
  assign out_o.format_kind     = kind_q;
  assign out_o.error_code      = err_q;
  assign out_o.sequence_number = seq_q;

endmodule
